/* sv/cse_pkg.sv */
// Shared types, sizes and codes for the counting semaphore engine.
package cse_pkg;

  localparam int NUM_SEMS   = 32;
  localparam int NUM_PROCS  = 32;
  localparam int COUNT_BITS = 8;

  localparam int SEM_W   = $clog2(NUM_SEMS);
  localparam int PROC_W  = $clog2(NUM_PROCS);
  localparam int ALLOC_W = $clog2(NUM_SEMS + 1);
  localparam int LEN_W   = $clog2(NUM_PROCS + 1);
  localparam int WAIT_DEPTH = NUM_SEMS * NUM_PROCS;
  localparam int WAIT_AW    = SEM_W + PROC_W;
  localparam int PID_W      = 5;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_LOCK   = 2'd1;
  localparam logic [1:0] OP_UNLOCK = 2'd2;

  localparam logic [3:0] ST_GRANTED   = 4'd0;
  localparam logic [3:0] ST_SUSPENDED = 4'd1;
  localparam logic [3:0] ST_HANDED    = 4'd2;
  localparam logic [3:0] ST_RELEASED  = 4'd3;
  localparam logic [3:0] ST_CREATED   = 4'd4;
  localparam logic [3:0] ST_NO_FREE   = 4'd5;
  localparam logic [3:0] ST_SATURATED = 4'd6;
  localparam logic [3:0] ST_WAIT_FULL = 4'd7;
  localparam logic [3:0] ST_BAD_OP    = 4'd8;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] sem_id;
    logic [4:0] requester_pid;
    logic [7:0] initial_count;
  } req_t;

  typedef struct packed {
    logic [3:0] status;
    logic [4:0] woken_pid;
    logic [4:0] new_sem_id;
  } rsp_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [PROC_W-1:0]     head;
    logic [PROC_W-1:0]     tail;
    logic [LEN_W-1:0]      len;
  } sem_rec_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

/* sv/cse_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module cse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/cse_ctrl.sv */
// Request sequencer: accepts an item, runs it through the execute state, strobes the result.
module cse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output cse_pkg::cmd_t     cmd
);

  typedef enum logic {IDLE, EXEC} state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          done  <= 1'b1;
          state <= IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= IDLE;
        end
      endcase
    end
  end

  assign busy     = (state == EXEC);
  assign cmd.load = start && (state == IDLE);
  assign cmd.exec = (state == EXEC);

endmodule

/* sv/cse_datapath.sv */
// Semaphore table, id allocator, wait queue store and result register.
module cse_datapath (
  input  logic              clk,
  input  logic              rst,
  input  cse_pkg::cmd_t     cmd,
  input  cse_pkg::req_t     req,
  output cse_pkg::rsp_t     rsp
);

  cse_pkg::req_t                        q;
  cse_pkg::sem_rec_t                    recs [cse_pkg::NUM_SEMS];
  logic [cse_pkg::ALLOC_W-1:0]          alloc;
  cse_pkg::sem_rec_t                    rec;
  cse_pkg::sem_rec_t                    rec_next;
  logic [cse_pkg::SEM_W-1:0]            rd_idx;
  logic [cse_pkg::SEM_W-1:0]            wr_idx;
  logic                                 rec_we;
  logic                                 alloc_inc;
  cse_pkg::rsp_t                        rsp_next;
  logic                                 ram_we;
  logic [cse_pkg::WAIT_AW-1:0]          ram_waddr;
  logic [cse_pkg::WAIT_AW-1:0]          ram_raddr;
  logic [cse_pkg::PID_W-1:0]            ram_rdata;

  // One table read port: the incoming item's semaphore while idle, the held one during execute.
  assign rd_idx = cmd.exec ? cse_pkg::SEM_W'(q.sem_id) : cse_pkg::SEM_W'(req.sem_id);
  assign rec    = recs[rd_idx];

  // Fetch the oldest waiter alongside acceptance so it is ready in the execute cycle.
  assign ram_raddr = {rd_idx, rec.head};
  assign ram_waddr = {cse_pkg::SEM_W'(q.sem_id), rec.tail};

  cse_ram #(
    .WIDTH (cse_pkg::PID_W),
    .DEPTH (cse_pkg::WAIT_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q.requester_pid),
    .re    (cmd.load),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    rsp_next  = '0;
    rsp_next.status = cse_pkg::ST_BAD_OP;
    rec_next  = rec;
    rec_we    = 1'b0;
    ram_we    = 1'b0;
    alloc_inc = 1'b0;
    wr_idx    = cse_pkg::SEM_W'(q.sem_id);
    unique case (q.opcode)
      cse_pkg::OP_CREATE: begin
        if (32'(alloc) >= cse_pkg::NUM_SEMS) begin
          rsp_next.status = cse_pkg::ST_NO_FREE;
        end else begin
          wr_idx = alloc[cse_pkg::SEM_W-1:0];
          rec_we = 1'b1;
          alloc_inc = 1'b1;
          rec_next = '0;
          if (32'(q.initial_count) > 32'(cse_pkg::CNT_MAX)) begin
            rec_next.count = cse_pkg::CNT_MAX;
          end else begin
            rec_next.count = cse_pkg::COUNT_BITS'(q.initial_count);
          end
          rsp_next.status     = cse_pkg::ST_CREATED;
          rsp_next.new_sem_id = 5'(alloc);
        end
      end
      cse_pkg::OP_LOCK: begin
        if (32'(q.sem_id) < cse_pkg::NUM_SEMS) begin
          if (rec.count != '0) begin
            rec_we = 1'b1;
            rec_next.count = rec.count - 1'b1;
            rsp_next.status = cse_pkg::ST_GRANTED;
          end else if (32'(rec.len) >= cse_pkg::NUM_PROCS) begin
            rsp_next.status = cse_pkg::ST_WAIT_FULL;
          end else begin
            rec_we = 1'b1;
            ram_we = 1'b1;
            rec_next.tail = (32'(rec.tail) == cse_pkg::NUM_PROCS - 1) ? '0
                                                                      : rec.tail + 1'b1;
            rec_next.len  = rec.len + 1'b1;
            rsp_next.status = cse_pkg::ST_SUSPENDED;
          end
        end
      end
      cse_pkg::OP_UNLOCK: begin
        if (32'(q.sem_id) < cse_pkg::NUM_SEMS) begin
          if (rec.len != '0) begin
            rec_we = 1'b1;
            rec_next.head = (32'(rec.head) == cse_pkg::NUM_PROCS - 1) ? '0
                                                                      : rec.head + 1'b1;
            rec_next.len  = rec.len - 1'b1;
            rsp_next.status    = cse_pkg::ST_HANDED;
            rsp_next.woken_pid = 5'(ram_rdata);
          end else if (rec.count == cse_pkg::CNT_MAX) begin
            rsp_next.status = cse_pkg::ST_SATURATED;
          end else begin
            rec_we = 1'b1;
            rec_next.count = rec.count + 1'b1;
            rsp_next.status = cse_pkg::ST_RELEASED;
          end
        end
      end
      default: begin
        rsp_next.status = cse_pkg::ST_BAD_OP;
      end
    endcase
    // Writes only land during execute.
    if (!cmd.exec) begin
      rec_we    = 1'b0;
      ram_we    = 1'b0;
      alloc_inc = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc <= '0;
      for (int i = 0; i < cse_pkg::NUM_SEMS; i++) begin
        recs[i] <= '0;
      end
    end else begin
      if (alloc_inc) begin
        alloc <= alloc + 1'b1;
      end
      if (rec_we) begin
        recs[wr_idx] <= rec_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q <= req;
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* sv/counting_semaphore_engine_unit.sv */
// Top level of the counting semaphore engine: sequencer plus datapath.
//
// Usage:
//   An item (req: opcode, sem_id, requester_pid, initial_count) is taken at a
//   rising edge where start is high and busy is low. busy rises for the one
//   execute cycle that follows.
//   The result (rsp: status, woken_pid, new_sem_id) is shown for exactly one
//   cycle with done high, in the cycle after the execute cycle; the receiver
//   has no way to hold it off and must take it then.
//   Items do not overlap: no new item is taken while busy is high. The accept
//   cycle reads the semaphore record and starts the wait-queue RAM read; the
//   execute cycle updates the record and writes the queue. A new item may be
//   taken in the cycle the previous result is on the ports.
//   Reset (rst, synchronous): all counts, queue pointers and lengths clear,
//   and the id allocator restarts at id 0. The wait-queue RAM is not cleared;
//   queue entries are only read after being written.
//   Ids are handed out in order and never returned.
module counting_semaphore_engine_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cse_pkg::req_t   req,
  output logic            busy,
  output logic            done,
  output cse_pkg::rsp_t   rsp
);

  cse_pkg::cmd_t cmd;

  cse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  cse_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

/* test/tb_counting_semaphore_engine_unit.sv */
// Self-checking testbench for the counting semaphore engine: directed table, a queue flood, then random items.
`timescale 1ns / 1ps

module tb_counting_semaphore_engine_unit;

  localparam logic [1:0] OP_BAD = 2'd3;
  localparam int RANDOM_ITEMS = 1530;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    cse_pkg::req_t r;
    bit            typed;
    cse_pkg::rsp_t fixed;
  } row_t;

  logic           clk;
  logic           rst;
  logic           start;
  cse_pkg::req_t  req;
  logic           busy;
  logic           done;
  cse_pkg::rsp_t  rsp;

  // semaphore table as the block should hold it
  logic [cse_pkg::COUNT_BITS-1:0] sem_units [cse_pkg::NUM_SEMS];
  logic [cse_pkg::PROC_W-1:0]     waiters   [cse_pkg::NUM_SEMS][cse_pkg::NUM_PROCS];
  logic [cse_pkg::PROC_W-1:0]     wq_head   [cse_pkg::NUM_SEMS];
  logic [cse_pkg::PROC_W-1:0]     wq_tail   [cse_pkg::NUM_SEMS];
  logic [cse_pkg::LEN_W-1:0]      wq_len    [cse_pkg::NUM_SEMS];
  logic [cse_pkg::SEM_W-1:0]      next_free;
  logic [cse_pkg::ALLOC_W-1:0]    free_left;

  cse_pkg::rsp_t pending_rsp [$];
  cse_pkg::rsp_t want;
  int   errors;
  int   cycles;
  int   items_sent;
  int   burst_left;
  int   status_seen [16];

  counting_semaphore_engine_unit dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_table();
    for (int i = 0; i < cse_pkg::NUM_SEMS; i++) begin
      sem_units[i] = '0;
      wq_head[i]   = '0;
      wq_tail[i]   = '0;
      wq_len[i]    = '0;
    end
    next_free = '0;
    free_left = cse_pkg::ALLOC_W'(cse_pkg::NUM_SEMS);
  endfunction

  // work out the result of one item and advance the table
  function automatic cse_pkg::rsp_t semaphore_outcome(input cse_pkg::req_t r);
    cse_pkg::rsp_t             o;
    logic [cse_pkg::SEM_W-1:0] s;
    o = '0;
    o.status = cse_pkg::ST_BAD_OP;
    s = r.sem_id[cse_pkg::SEM_W-1:0];
    if (r.opcode == cse_pkg::OP_CREATE) begin
      if (free_left == 0) begin
        o.status = cse_pkg::ST_NO_FREE;
      end else begin
        sem_units[next_free] = (r.initial_count > cse_pkg::CNT_MAX)
                               ? cse_pkg::CNT_MAX : cse_pkg::COUNT_BITS'(r.initial_count);
        wq_head[next_free] = '0;
        wq_tail[next_free] = '0;
        wq_len[next_free]  = '0;
        o.new_sem_id = 5'(next_free);
        o.status     = cse_pkg::ST_CREATED;
        next_free    = next_free + 1'b1;
        free_left    = free_left - 1'b1;
      end
    end else if ((r.opcode == cse_pkg::OP_LOCK || r.opcode == cse_pkg::OP_UNLOCK) &&
                 int'(r.sem_id) < cse_pkg::NUM_SEMS) begin
      if (r.opcode == cse_pkg::OP_LOCK) begin
        if (sem_units[s] > 0) begin
          sem_units[s] = sem_units[s] - 1'b1;
          o.status = cse_pkg::ST_GRANTED;
        end else if (wq_len[s] >= cse_pkg::NUM_PROCS) begin
          o.status = cse_pkg::ST_WAIT_FULL;
        end else begin
          waiters[s][wq_tail[s]] = cse_pkg::PROC_W'(r.requester_pid);
          wq_tail[s] = wq_tail[s] + 1'b1;
          wq_len[s]  = wq_len[s] + 1'b1;
          o.status = cse_pkg::ST_SUSPENDED;
        end
      end else begin
        if (wq_len[s] > 0) begin
          o.woken_pid = 5'(waiters[s][wq_head[s]]);
          wq_head[s] = wq_head[s] + 1'b1;
          wq_len[s]  = wq_len[s] - 1'b1;
          o.status = cse_pkg::ST_HANDED;
        end else if (sem_units[s] == cse_pkg::CNT_MAX) begin
          o.status = cse_pkg::ST_SATURATED;
        end else begin
          sem_units[s] = sem_units[s] + 1'b1;
          o.status = cse_pkg::ST_RELEASED;
        end
      end
    end
    return o;
  endfunction

  function automatic row_t mk(input logic [1:0] op, input logic [4:0] sid,
                              input logic [4:0] pid, input logic [7:0] init,
                              input bit typed = 1'b0, input logic [3:0] st = '0,
                              input logic [4:0] wk = '0, input logic [4:0] nid = '0);
    row_t x;
    x.r.opcode        = op;
    x.r.sem_id        = sid;
    x.r.requester_pid = pid;
    x.r.initial_count = init;
    x.typed           = typed;
    x.fixed.status     = st;
    x.fixed.woken_pid  = wk;
    x.fixed.new_sem_id = nid;
    return x;
  endfunction

  function automatic cse_pkg::req_t shape_req(input logic [1:0] op, input logic [4:0] sid);
    cse_pkg::req_t r;
    r.opcode        = op;
    r.sem_id        = sid;
    r.requester_pid = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 9))
      0: r.initial_count = 8'd0;
      1: r.initial_count = 8'd255;
      default: r.initial_count = 8'($urandom_range(0, 255));
    endcase
    return r;
  endfunction

  // present one item, hold until taken, then queue its expected result
  task automatic issue(input cse_pkg::req_t r, input bit typed = 1'b0,
                       input cse_pkg::rsp_t fixed = '0);
    cse_pkg::rsp_t predicted;
    int            gap;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    predicted = semaphore_outcome(r);
    pending_rsp.push_back(typed ? fixed : predicted);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
  endtask

  // hold start low until every result is back
  task automatic wait_all_back();
    start <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  // fill one wait queue to the brim, knock on it once or twice more, then drain it
  task automatic flood_queue(input logic [4:0] s);
    int guard;
    guard = 0;
    while (wq_len[s] < cse_pkg::NUM_PROCS && guard < 80) begin
      issue(shape_req(cse_pkg::OP_LOCK, s));
      guard++;
    end
    repeat ($urandom_range(1, 2)) issue(shape_req(cse_pkg::OP_LOCK, s));
    repeat ($urandom_range(cse_pkg::NUM_PROCS, cse_pkg::NUM_PROCS + 3))
      issue(shape_req(cse_pkg::OP_UNLOCK, s));
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_rsp.size());
      $display("FAILURE");
      $finish;
    end else if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("result with nothing outstanding: status %0d", rsp.status);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        status_seen[rsp.status]++;
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          errors++;
        end
        if (rsp.woken_pid !== want.woken_pid) begin
          $error("woken_pid: expected %0d, got %0d", want.woken_pid, rsp.woken_pid);
          errors++;
        end
        if (rsp.new_sem_id !== want.new_sem_id) begin
          $error("new_sem_id: expected %0d, got %0d", want.new_sem_id, rsp.new_sem_id);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t             plan [$];
    int               sent_random;
    int               kind;
    logic [4:0]       s;
    clk        = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    errors     = 0;
    cycles     = 0;
    items_sent = 0;
    burst_left = 8;
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_table();

    // untouched semaphores act on their reset state; then the id allocator
    plan.push_back(mk(cse_pkg::OP_LOCK,   5'd0,  5'd31, 8'd0,   1, cse_pkg::ST_SUSPENDED));
    plan.push_back(mk(cse_pkg::OP_LOCK,   5'd0,  5'd0,  8'd255, 1, cse_pkg::ST_SUSPENDED));
    plan.push_back(mk(cse_pkg::OP_UNLOCK, 5'd0,  5'd7,  8'd0,   1, cse_pkg::ST_HANDED, 5'd31));
    plan.push_back(mk(cse_pkg::OP_UNLOCK, 5'd0,  5'd7,  8'd0,   1, cse_pkg::ST_HANDED, 5'd0));
    plan.push_back(mk(cse_pkg::OP_UNLOCK, 5'd0,  5'd9,  8'd0,   1, cse_pkg::ST_RELEASED));
    plan.push_back(mk(cse_pkg::OP_LOCK,   5'd0,  5'd3,  8'd0,   1, cse_pkg::ST_GRANTED));
    plan.push_back(mk(OP_BAD,             5'd31, 5'd31, 8'd255, 1, cse_pkg::ST_BAD_OP));
    plan.push_back(mk(cse_pkg::OP_CREATE, 5'd17, 5'd4,  8'd255,
                      1, cse_pkg::ST_CREATED, 5'd0, 5'd0));
    plan.push_back(mk(cse_pkg::OP_UNLOCK, 5'd0,  5'd2,  8'd0,   1, cse_pkg::ST_SATURATED));
    plan.push_back(mk(cse_pkg::OP_LOCK,   5'd0,  5'd2,  8'd0));
    plan.push_back(mk(cse_pkg::OP_CREATE, 5'd0,  5'd0,  8'd0,
                      1, cse_pkg::ST_CREATED, 5'd0, 5'd1));
    plan.push_back(mk(cse_pkg::OP_LOCK,   5'd1,  5'd21, 8'd0));
    plan.push_back(mk(cse_pkg::OP_LOCK,   5'd1,  5'd10, 8'd0));
    plan.push_back(mk(cse_pkg::OP_CREATE, 5'd31, 5'd31, 8'd128,
                      1, cse_pkg::ST_CREATED, 5'd0, 5'd2));
    plan.push_back(mk(cse_pkg::OP_UNLOCK, 5'd1,  5'd0,  8'd0));
    plan.push_back(mk(cse_pkg::OP_UNLOCK, 5'd1,  5'd0,  8'd0));
    plan.push_back(mk(cse_pkg::OP_UNLOCK, 5'd1,  5'd0,  8'd0));
    plan.push_back(mk(cse_pkg::OP_UNLOCK, 5'd30, 5'd16, 8'd1));
    plan.push_back(mk(OP_BAD,             5'd0,  5'd0,  8'd0,   1, cse_pkg::ST_BAD_OP));
    plan.push_back(mk(cse_pkg::OP_LOCK,   5'd2,  5'd10, 8'd255));
    plan.push_back(mk(cse_pkg::OP_LOCK,   5'd30, 5'd15, 8'd127));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) issue(plan[i].r, plan[i].typed, plan[i].fixed);
    wait_all_back();

    // a full wait queue on a semaphore nobody has touched
    sent_random = items_sent;
    flood_queue(5'd31);

    while (items_sent - sent_random < RANDOM_ITEMS) begin
      // favour a few semaphores so their queues build up
      s = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
      kind = $urandom_range(0, 99);
      if (kind < 2 && sem_units[s] < 40) begin
        flood_queue(s);
      end else if (kind < 8) begin
        issue(shape_req(cse_pkg::OP_CREATE, 5'($urandom_range(0, 31))));
      end else if (kind < 53) begin
        issue(shape_req(cse_pkg::OP_LOCK, s));
      end else if (kind < 94) begin
        issue(shape_req(cse_pkg::OP_UNLOCK, s));
      end else begin
        issue(shape_req(OP_BAD, 5'($urandom_range(0, 31))));
      end
      if ($urandom_range(0, 199) == 0) wait_all_back();
    end

    wait_all_back();
    repeat (8) @(posedge clk);

    $display("%0d items: granted %0d, suspended %0d, handed over %0d, released %0d",
             items_sent, status_seen[cse_pkg::ST_GRANTED],
             status_seen[cse_pkg::ST_SUSPENDED], status_seen[cse_pkg::ST_HANDED],
             status_seen[cse_pkg::ST_RELEASED]);
    $display("created %0d, no free id %0d, saturated %0d, wait full %0d, bad opcode %0d",
             status_seen[cse_pkg::ST_CREATED], status_seen[cse_pkg::ST_NO_FREE],
             status_seen[cse_pkg::ST_SATURATED], status_seen[cse_pkg::ST_WAIT_FULL],
             status_seen[cse_pkg::ST_BAD_OP]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
